[rtl/imu_uart_frame_parser_defines.svh]
// Assertion macros shared by the parser modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef IMU_UART_FRAME_PARSER_DEFINES_SVH
`define IMU_UART_FRAME_PARSER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define IUFP_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define IUFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/iufp_pkg.sv]
`default_nettype none

package iufp_pkg;

    localparam int RAW_W    = 16;
    localparam int SCALED_W = 28;
    localparam int MUL_W    = 12;
    localparam int POS_W    = 4;
    localparam int DATA_BYTES = 6;
    localparam int DATA_IDX_W = $clog2(DATA_BYTES);

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_ACCEL  = 8'h51;
    localparam logic [7:0] TYPE_ANGLE  = 8'h53;

    localparam logic [POS_W-1:0] POS_HEADER   = 4'd0;
    localparam logic [POS_W-1:0] POS_TYPE     = 4'd1;
    localparam logic [POS_W-1:0] POS_DATA     = 4'd2;
    localparam logic [POS_W-1:0] POS_DATA_END = 4'd8;
    localparam logic [POS_W-1:0] POS_LAST     = 4'd10;

    localparam logic [MUL_W-1:0] ACCEL_MUL = 12'd32;
    localparam logic [MUL_W-1:0] RATE_MUL  = 12'd4000;
    localparam logic [MUL_W-1:0] ANGLE_MUL = 12'd360;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CHECKSUM = 2'd1,
        STATUS_TYPE     = 2'd2,
        STATUS_LINE     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } kind_t;

    typedef struct packed {
        logic                    valid;
        status_t                 status;
        kind_t                   kind;
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
    } frame_t;

    typedef struct packed {
        status_t                    status;
        kind_t                      kind;
        logic signed [RAW_W-1:0]    raw_x;
        logic signed [RAW_W-1:0]    raw_y;
        logic signed [RAW_W-1:0]    raw_z;
        logic signed [SCALED_W-1:0] scaled_x;
        logic signed [SCALED_W-1:0] scaled_y;
        logic signed [SCALED_W-1:0] scaled_z;
        logic                       new_attitude;
    } result_t;

endpackage

`default_nettype wire

[rtl/iufp_assembler.sv]
`default_nettype none
`include "imu_uart_frame_parser_defines.svh"

module iufp_assembler (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    input  logic            in_lerr,
    output iufp_pkg::frame_t frame
);
    import iufp_pkg::*;

    logic                  in_valid_reg;
    logic [7:0]            byte_reg;
    logic                  lerr_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [7:0]            sum_reg;
    logic [7:0]            sum_next;
    logic [7:0]            type_reg;
    logic [7:0]            data_reg [DATA_BYTES];
    logic                  type_we;
    logic                  data_we;
    logic [POS_W-1:0]      pos_eff;
    logic [POS_W-1:0]      data_off;
    logic [DATA_IDX_W-1:0] data_idx;
    logic [7:0]            kind_off;
    logic                  type_ok;
    logic                  proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            byte_reg <= in_byte;
            lerr_reg <= in_lerr;
        end
    end

    assign proc     = en && in_valid_reg;
    assign pos_eff  = (pos_reg > POS_LAST) ? POS_HEADER : pos_reg;
    assign data_off = pos_eff - POS_DATA;
    assign data_idx = data_off[DATA_IDX_W-1:0];
    assign kind_off = type_reg - TYPE_ACCEL;
    assign type_ok  = (byte_reg >= TYPE_ACCEL) && (byte_reg <= TYPE_ANGLE);

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        type_we  = 1'b0;
        data_we  = 1'b0;
        frame    = '0;
        if (proc)
        begin
            if (lerr_reg)
            begin
                pos_next     = POS_HEADER;
                frame.valid  = 1'b1;
                frame.status = STATUS_LINE;
            end
            else if (pos_eff == POS_HEADER)
            begin
                pos_next = POS_HEADER;
                if (byte_reg == HEADER_BYTE)
                begin
                    pos_next = POS_TYPE;
                    sum_next = byte_reg;
                end
            end
            else if (pos_eff == POS_TYPE)
            begin
                if (type_ok)
                begin
                    pos_next = POS_DATA;
                    sum_next = sum_reg + byte_reg;
                    type_we  = 1'b1;
                end
                else
                begin
                    pos_next     = POS_HEADER;
                    frame.valid  = 1'b1;
                    frame.status = STATUS_TYPE;
                end
            end
            else if (pos_eff == POS_LAST)
            begin
                pos_next    = POS_HEADER;
                frame.valid = 1'b1;
                if (sum_reg == byte_reg)
                begin
                    frame.status = STATUS_OK;
                    frame.kind   = kind_t'(kind_off[1:0]);
                    frame.raw_x  = $signed({data_reg[1], data_reg[0]});
                    frame.raw_y  = $signed({data_reg[3], data_reg[2]});
                    frame.raw_z  = $signed({data_reg[5], data_reg[4]});
                end
                else
                begin
                    frame.status = STATUS_CHECKSUM;
                end
            end
            else
            begin
                pos_next = pos_eff + 1'b1;
                sum_next = sum_reg + byte_reg;
                data_we  = (pos_eff < POS_DATA_END);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HEADER;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (type_we)
        begin
            type_reg <= byte_reg;
        end
        if (data_we)
        begin
            data_reg[data_idx] <= byte_reg;
        end
    end

    `IUFP_ASSERT(a_pos_range, pos_reg <= POS_LAST, "Frame position ran past the checksum byte.")
    `IUFP_ASSERT_NEXT(a_line_resync, proc && lerr_reg, pos_reg == POS_HEADER,
        "A line error did not return the parser to header search.")
    `IUFP_ASSERT_NEXT(a_type_resync, frame.valid && (frame.status == STATUS_TYPE),
        pos_reg == POS_HEADER, "A bad type byte did not return the parser to header search.")
    `IUFP_ASSERT(a_result_source, !frame.valid || proc,
        "A result appeared without a transaction in the input register.")

endmodule

`default_nettype wire

[rtl/iufp_scaler.sv]
`default_nettype none
`include "imu_uart_frame_parser_defines.svh"

module iufp_scaler (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  iufp_pkg::frame_t  frame,
    output logic              out_valid,
    output iufp_pkg::result_t result
);
    import iufp_pkg::*;

    logic                       valid_reg;
    result_t                    result_reg;
    result_t                    result_next;
    logic [MUL_W-1:0]           mul;
    logic signed [MUL_W:0]      mul_s;
    logic signed [SCALED_W:0]   prod_x;
    logic signed [SCALED_W:0]   prod_y;
    logic signed [SCALED_W:0]   prod_z;

    always_comb
    begin
        case (frame.kind)
            KIND_ACCEL: mul = ACCEL_MUL;
            KIND_RATE:  mul = RATE_MUL;
            KIND_ANGLE: mul = ANGLE_MUL;
            default:    mul = '0;
        endcase
    end

    assign mul_s  = $signed({1'b0, mul});
    assign prod_x = frame.raw_x * mul_s;
    assign prod_y = frame.raw_y * mul_s;
    assign prod_z = frame.raw_z * mul_s;

    always_comb
    begin
        result_next.status       = frame.status;
        result_next.kind         = frame.kind;
        result_next.raw_x        = frame.raw_x;
        result_next.raw_y        = frame.raw_y;
        result_next.raw_z        = frame.raw_z;
        result_next.scaled_x     = $signed(prod_x[SCALED_W-1:0]);
        result_next.scaled_y     = $signed(prod_y[SCALED_W-1:0]);
        result_next.scaled_z     = $signed(prod_z[SCALED_W-1:0]);
        result_next.new_attitude = (frame.status == STATUS_OK) && (frame.kind != KIND_ACCEL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= frame.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && frame.valid)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

    `IUFP_ASSERT(a_error_zeroed,
        !valid_reg || (result_reg.status == STATUS_OK) ||
        ((result_reg.kind == KIND_ACCEL) && (result_reg.raw_x == 0) &&
         (result_reg.raw_y == 0) && (result_reg.raw_z == 0) && !result_reg.new_attitude),
        "An error result carries nonzero data.")
    `IUFP_ASSERT(a_attitude_kind, !valid_reg || !result_reg.new_attitude ||
        (result_reg.kind != KIND_ACCEL), "Attitude flag raised for an acceleration frame.")

endmodule

`default_nettype wire

[rtl/imu_uart_frame_parser.sv]
// IMU UART frame parser.
// The slave channel takes one received UART byte per transaction: tdata holds the
// byte and tuser the line-error flag of that byte. Bytes are assembled into
// 11-byte frames (header 0x55, type 0x51..0x53, six data bytes, two spare bytes,
// checksum). The master channel gives one transaction per finished frame and one
// per error: a bad type byte, a checksum mismatch or a line error. Header bytes
// that do not match are dropped without a transaction.
// Throughput is one byte per cycle while the receiver does not stall. A byte is
// first captured in the input register; its result is then registered in the
// output register, where it waits until the receiver takes it. The frame
// position, running checksum and data bytes are updated as the byte passes from
// the input register to the output register; the scaling multipliers sit
// directly in front of the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_axis_tready drops; bytes that cause no result still move while the output
// register is empty or being taken.
// Reset clears the valid flags and returns the parser to header search.
`default_nettype none

module imu_uart_frame_parser (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0: rx_byte[7:0].
    input  logic [7:0]   s_axis_tdata,
    // Fields from bit 0: line_error.
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0: raw_x[15:0], raw_y[31:16], raw_z[47:32], scaled_x[75:48],
    // scaled_y[103:76], scaled_z[131:104], new_attitude[132], zero fill[135:133].
    output logic [135:0] m_axis_tdata,
    // Fields from bit 0: status[1:0], frame_kind[3:2].
    output logic [3:0]   m_axis_tuser
);
    import iufp_pkg::*;

    logic    en;
    frame_t  frame;
    result_t result;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    iufp_assembler u_assembler (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata),
        .in_lerr  (s_axis_tuser),
        .frame    (frame)
    );

    iufp_scaler u_scaler (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .frame     (frame),
        .out_valid (m_axis_tvalid),
        .result    (result)
    );

    assign m_axis_tdata = {3'b000, result.new_attitude, result.scaled_z, result.scaled_y,
                           result.scaled_x, result.raw_z, result.raw_y, result.raw_x};
    assign m_axis_tuser = {result.kind, result.status};

endmodule

`default_nettype wire
